### rtl/mi4_pkg.sv
package mi4_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int ELEMENT_WIDTH = 32;

    localparam int MAG_W = 64;
    localparam int ACC_W = 132;
    localparam int NUM_W = 98;
    localparam int REM_W = 65;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int DET_SH = 2 * FRACTION_BITS;

    localparam logic [NUM_W-1:0] MAXPOS = NUM_W'((64'd1 << (ELEMENT_WIDTH - 1)) - 64'd1);
    localparam bit ID_CLIP = (FRACTION_BITS >= ELEMENT_WIDTH - 1);
    localparam logic [31:0] ID_ONE = ID_CLIP ? 32'(MAXPOS) : 32'(64'd1 << FRACTION_BITS);

    typedef logic [15:0][ELEMENT_WIDTH-1:0] matrix_t;

    typedef struct packed {
        logic [1:0]         outer_index;
        logic [1:0]         inner_index;
        logic signed [31:0] element_value;
        logic               start_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_outer_index;
        logic [1:0]         out_inner_index;
        logic signed [31:0] result_value;
        logic               singular;
        logic               saturated;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_MINOR,
        PH_DET,
        PH_COF
    } phase_t;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_FETCH_A,
        ENG_FETCH_B,
        ENG_FETCH_C,
        ENG_MUL,
        ENG_DRAIN,
        ENG_MINOR_WR,
        ENG_DET_MAG,
        ENG_DET_RND,
        ENG_DET_CHK,
        ENG_ID_BUILD,
        ENG_NUM,
        ENG_DIV,
        ENG_Q_RND,
        ENG_Q_SAT,
        ENG_EMIT
    } eng_state_t;

    typedef struct packed {
        logic       a_min;
        logic [3:0] a_idx;
        logic       b_min;
        logic [3:0] b_idx;
        logic       neg;
    } term_t;

    localparam logic [1:0] COL_P [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] COL_Q [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    localparam logic [5:0] DET_NEG = 6'b010010;

    localparam logic [3:0] COF_E [48] = '{
        4'd5, 4'd6, 4'd7,     4'd1, 4'd2, 4'd3,     4'd13, 4'd14, 4'd15,  4'd9, 4'd10, 4'd11,
        4'd4, 4'd6, 4'd7,     4'd0, 4'd2, 4'd3,     4'd12, 4'd14, 4'd15,  4'd8, 4'd10, 4'd11,
        4'd4, 4'd5, 4'd7,     4'd0, 4'd1, 4'd3,     4'd12, 4'd13, 4'd15,  4'd8, 4'd9, 4'd11,
        4'd4, 4'd5, 4'd6,     4'd0, 4'd1, 4'd2,     4'd12, 4'd13, 4'd14,  4'd8, 4'd9, 4'd10
    };
    localparam logic [3:0] COF_M [48] = '{
        4'd11, 4'd10, 4'd9,   4'd11, 4'd10, 4'd9,   4'd5, 4'd4, 4'd3,     4'd5, 4'd4, 4'd3,
        4'd11, 4'd8, 4'd7,    4'd11, 4'd8, 4'd7,    4'd5, 4'd2, 4'd1,     4'd5, 4'd2, 4'd1,
        4'd10, 4'd8, 4'd6,    4'd10, 4'd8, 4'd6,    4'd4, 4'd2, 4'd0,     4'd4, 4'd2, 4'd0,
        4'd9, 4'd7, 4'd6,     4'd9, 4'd7, 4'd6,     4'd3, 4'd1, 4'd0,     4'd3, 4'd1, 4'd0
    };

    function automatic logic [2:0] n_terms(input phase_t ph);
        logic [2:0] n;
        unique case (ph)
            PH_MINOR: n = 3'd2;
            PH_DET:   n = 3'd6;
            PH_COF:   n = 3'd3;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic term_t term_desc(input phase_t ph, input logic [3:0] g,
                                        input logic [2:0] t);
        term_t      d;
        logic [1:0] r;
        logic [1:0] r1;
        logic [2:0] c;
        logic [5:0] ix;
        d  = '0;
        r  = (g < 4'd6) ? 2'd0 : 2'd2;
        r1 = 2'(r + 2'd1);
        c  = (g < 4'd6) ? g[2:0] : 3'(g - 4'd6);
        ix = 6'(6'(g) * 6'd3 + 6'(t));
        unique case (ph)
            PH_MINOR:
            begin
                if (!t[0])
                begin
                    d.a_idx = {r, COL_P[c]};
                    d.b_idx = {r1, COL_Q[c]};
                    d.neg   = 1'b0;
                end
                else
                begin
                    d.a_idx = {r1, COL_P[c]};
                    d.b_idx = {r, COL_Q[c]};
                    d.neg   = 1'b1;
                end
            end
            PH_DET:
            begin
                d.a_min = 1'b1;
                d.b_min = 1'b1;
                d.a_idx = {1'b0, t};
                d.b_idx = 4'(4'd11 - {1'b0, t});
                d.neg   = DET_NEG[t];
            end
            PH_COF:
            begin
                d.a_idx = COF_E[ix];
                d.b_min = 1'b1;
                d.b_idx = COF_M[ix];
                d.neg   = (g[2] ^ g[0]) ^ (t == 3'd1);
            end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

### rtl/mi4_front.sv
module mi4_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mi4_pkg::in_item_t  item,
    output logic               job_valid,
    output mi4_pkg::matrix_t   job_mat,
    input  logic               job_take
);
    import mi4_pkg::*;

    matrix_t    matrix_reg;
    matrix_t    matrix_next;
    matrix_t    job_mat_reg;
    logic       job_valid_reg;
    logic       accept;
    logic [3:0] idx;

    assign full      = job_valid_reg;
    assign job_valid = job_valid_reg;
    assign job_mat   = job_mat_reg;
    assign accept    = push && !job_valid_reg;
    assign idx       = {item.outer_index, item.inner_index};

    always_comb
    begin
        matrix_next = matrix_reg;
        if (accept)
            matrix_next[idx] = item.element_value[ELEMENT_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg    <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            matrix_reg <= matrix_next;
            if (accept && item.start_req)
                job_valid_reg <= 1'b1;
            else if (job_take)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.start_req)
            job_mat_reg <= matrix_next;
    end

endmodule

### rtl/mi4_back.sv
module mi4_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  mi4_pkg::matrix_t   job_mat,
    output logic               job_take,
    input  logic [31:0]        threshold,
    output logic               res_push,
    output mi4_pkg::out_item_t res_item,
    input  logic               res_full
);
    import mi4_pkg::*;

    eng_state_t state_reg, state_next;
    phase_t     phase_reg;
    logic [3:0] grp_reg;
    logic [2:0] term_reg;
    logic [1:0] part_reg;
    logic       prod_vld_reg;

    matrix_t                   mat_reg;
    logic [MAG_W-1:0]          minor_mem [12];
    logic [ELEMENT_WIDTH-1:0]  mat_rd_reg;
    logic [MAG_W-1:0]          min_rd_reg;
    logic [MAG_W-1:0]          opa_reg, opb_reg;
    logic                      opa_sgn_reg, term_neg_reg;
    logic [63:0]               prod_reg;
    logic [1:0]                prod_sh_reg;
    logic                      prod_neg_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]          mag_reg;
    logic                      dsgn_reg;
    logic [63:0]               det_reg, dmag_reg;
    logic                      dneg_reg, sing_reg;
    logic [NUM_W-1:0]          num_reg, q_reg;
    logic                      cneg_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    out_item_t                 item_reg;

    term_t            tsel;
    logic             last_term;
    logic [3:0]       rd_e, rd_m;
    logic [MAG_W-1:0] rd_val, rd_mag;
    logic [ACC_W-1:0] addend;
    logic [63:0]      dmag_c;
    logic             sing_c;
    logic [ACC_W-1:0] rnd_c;
    logic [REM_W-1:0] r2_c, dm_c;
    logic             ge_c;
    logic             rneg_c, sat_c;
    logic [NUM_W-1:0] lim_c, val_c;
    logic [31:0]      a_half, b_half;

    assign tsel      = term_desc(phase_reg, grp_reg, term_reg);
    assign last_term = (term_reg == 3'(n_terms(phase_reg) - 3'd1));
    assign rd_e      = (state_reg == ENG_FETCH_A) ? tsel.a_idx : tsel.b_idx;
    assign rd_m      = rd_e;
    assign res_item  = item_reg;

    always_comb
    begin
        logic src_min;
        src_min = (state_reg == ENG_FETCH_B) ? tsel.a_min : tsel.b_min;
        rd_val  = src_min ? min_rd_reg : MAG_W'(signed'(mat_rd_reg));
        rd_mag  = rd_val[MAG_W-1] ? MAG_W'(-rd_val) : rd_val;
    end

    always_comb
    begin
        case (prod_sh_reg)
            2'd0:    addend = ACC_W'(prod_reg);
            2'd1:    addend = ACC_W'(prod_reg) << 32;
            2'd2:    addend = ACC_W'(prod_reg) << 64;
            default: addend = '0;
        endcase
        if (prod_neg_reg)
            addend = ACC_W'(-addend);
    end

    assign a_half = part_reg[0] ? opa_reg[63:32] : opa_reg[31:0];
    assign b_half = part_reg[1] ? opb_reg[63:32] : opb_reg[31:0];

    assign dmag_c = det_reg[63] ? 64'(-det_reg) : det_reg;
    assign sing_c = (dmag_c == 64'd0) || (dmag_c < 64'(threshold));
    assign rnd_c  = ACC_W'(mag_reg + (ACC_W'(1) << (DET_SH - 1))) >> DET_SH;

    assign dm_c = {1'b0, dmag_reg};
    assign r2_c = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign ge_c = (r2_c >= dm_c);

    assign rneg_c = cneg_reg ^ dneg_reg;
    assign lim_c  = rneg_c ? NUM_W'(MAXPOS + NUM_W'(1)) : MAXPOS;
    assign sat_c  = (q_reg > lim_c);
    assign val_c  = sat_c ? lim_c : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ENG_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        job_take   = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            ENG_IDLE:
                if (job_valid)
                begin
                    job_take   = 1'b1;
                    state_next = ENG_FETCH_A;
                end
            ENG_FETCH_A: state_next = ENG_FETCH_B;
            ENG_FETCH_B: state_next = ENG_FETCH_C;
            ENG_FETCH_C: state_next = ENG_MUL;
            ENG_MUL:
                if (part_reg == 2'd3)
                    state_next = last_term ? ENG_DRAIN : ENG_FETCH_A;
            ENG_DRAIN:
                unique case (phase_reg)
                    PH_MINOR: state_next = ENG_MINOR_WR;
                    PH_DET:   state_next = ENG_DET_MAG;
                    default:  state_next = ENG_NUM;
                endcase
            ENG_MINOR_WR: state_next = ENG_FETCH_A;
            ENG_DET_MAG:  state_next = ENG_DET_RND;
            ENG_DET_RND:  state_next = ENG_DET_CHK;
            ENG_DET_CHK:  state_next = sing_c ? ENG_ID_BUILD : ENG_FETCH_A;
            ENG_ID_BUILD: state_next = ENG_EMIT;
            ENG_NUM:      state_next = ENG_DIV;
            ENG_DIV:
                if (cnt_reg == '0)
                    state_next = ENG_Q_RND;
            ENG_Q_RND:    state_next = ENG_Q_SAT;
            ENG_Q_SAT:    state_next = ENG_EMIT;
            ENG_EMIT:
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (grp_reg == 4'd15)
                        state_next = ENG_IDLE;
                    else
                        state_next = sing_reg ? ENG_ID_BUILD : ENG_FETCH_A;
                end
            default: state_next = ENG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MINOR;
            grp_reg      <= '0;
            term_reg     <= '0;
            part_reg     <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= (state_reg == ENG_MUL);
            unique case (state_reg)
                ENG_IDLE:
                begin
                    phase_reg <= PH_MINOR;
                    grp_reg   <= '0;
                    term_reg  <= '0;
                    part_reg  <= '0;
                end
                ENG_MUL:
                begin
                    part_reg <= 2'(part_reg + 2'd1);
                    if (part_reg == 2'd3 && !last_term)
                        term_reg <= 3'(term_reg + 3'd1);
                end
                ENG_MINOR_WR:
                begin
                    term_reg <= '0;
                    if (grp_reg == 4'd11)
                    begin
                        phase_reg <= PH_DET;
                        grp_reg   <= '0;
                    end
                    else
                        grp_reg <= 4'(grp_reg + 4'd1);
                end
                ENG_DET_CHK:
                begin
                    phase_reg <= PH_COF;
                    grp_reg   <= '0;
                    term_reg  <= '0;
                end
                ENG_EMIT:
                    if (!res_full && grp_reg != 4'd15)
                    begin
                        grp_reg  <= 4'(grp_reg + 4'd1);
                        term_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mat_rd_reg <= mat_reg[rd_e];
        min_rd_reg <= minor_mem[rd_m];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ENG_MINOR_WR)
            minor_mem[grp_reg] <= acc_reg[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= 64'(a_half) * 64'(b_half);
        prod_sh_reg  <= 2'({1'b0, part_reg[0]} + {1'b0, part_reg[1]});
        prod_neg_reg <= term_neg_reg;

        if (state_reg == ENG_IDLE || state_reg == ENG_MINOR_WR ||
            state_reg == ENG_DET_MAG || state_reg == ENG_NUM)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= ACC_W'(acc_reg + addend);

        unique case (state_reg)
            ENG_IDLE:
                if (job_valid)
                    mat_reg <= job_mat;
            ENG_FETCH_B:
            begin
                opa_reg     <= rd_mag;
                opa_sgn_reg <= rd_val[MAG_W-1];
            end
            ENG_FETCH_C:
            begin
                opb_reg      <= rd_mag;
                term_neg_reg <= opa_sgn_reg ^ rd_val[MAG_W-1] ^ tsel.neg;
            end
            ENG_DET_MAG:
            begin
                dsgn_reg <= acc_reg[ACC_W-1];
                mag_reg  <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            end
            ENG_DET_RND:
                if (dsgn_reg)
                    det_reg <= (rnd_c > (ACC_W'(1) << 63)) ? 64'h8000_0000_0000_0000
                                                           : 64'(-rnd_c[63:0]);
                else
                    det_reg <= (rnd_c > ((ACC_W'(1) << 63) - ACC_W'(1)))
                               ? 64'h7FFF_FFFF_FFFF_FFFF : rnd_c[63:0];
            ENG_DET_CHK:
            begin
                dmag_reg <= dmag_c;
                dneg_reg <= det_reg[63];
                sing_reg <= sing_c;
            end
            ENG_ID_BUILD:
            begin
                item_reg.out_outer_index <= grp_reg[3:2];
                item_reg.out_inner_index <= grp_reg[1:0];
                item_reg.result_value    <= (grp_reg[3:2] == grp_reg[1:0]) ? ID_ONE : '0;
                item_reg.singular        <= 1'b1;
                item_reg.saturated       <= (grp_reg[3:2] == grp_reg[1:0]) && ID_CLIP;
                item_reg.last            <= (grp_reg == 4'd15);
            end
            ENG_NUM:
            begin
                cneg_reg <= acc_reg[ACC_W-1];
                num_reg  <= acc_reg[ACC_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            ENG_DIV:
            begin
                rem_reg <= ge_c ? REM_W'(r2_c - dm_c) : r2_c;
                q_reg   <= {q_reg[NUM_W-2:0], ge_c};
                num_reg <= num_reg << 1;
                cnt_reg <= CNT_W'(cnt_reg - 1'b1);
            end
            ENG_Q_RND:
                if (rem_reg >= REM_W'(dm_c - rem_reg))
                    q_reg <= NUM_W'(q_reg + NUM_W'(1));
            ENG_Q_SAT:
            begin
                item_reg.out_outer_index <= grp_reg[3:2];
                item_reg.out_inner_index <= grp_reg[1:0];
                item_reg.result_value    <= rneg_c ? 32'(-val_c) : 32'(val_c);
                item_reg.singular        <= 1'b0;
                item_reg.saturated       <= sat_c;
                item_reg.last            <= (grp_reg == 4'd15);
            end
            default: ;
        endcase
    end

endmodule

### rtl/mi4_outq.sv
module mi4_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  mi4_pkg::out_item_t wr_item,
    output logic               wr_full,
    input  logic               rd,
    output mi4_pkg::out_item_t rd_item,
    output logic               rd_empty
);
    import mi4_pkg::*;

    out_item_t  mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_full  = (cnt_reg == 2'd2);
    assign rd_empty = (cnt_reg == 2'd0);
    assign rd_item  = mem[rp_reg];
    assign do_wr    = wr && !wr_full;
    assign do_rd    = rd && !rd_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= !wp_reg;
            if (do_rd)
                rp_reg <= !rp_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, do_wr} - {1'b0, do_rd});
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_item;
    end

endmodule

### rtl/matrix_inverse_4x4.sv
// channel   dir  handshake               payload
// item      in   push / full             in_item_t: one element, start_req
// result    out  pop / empty             out_item_t: one inverse element
// cfg       in   cfg_valid / cfg_ready   singular_threshold, 32 bits
//
// Each pushed item is loaded into the matrix; a start item is then handed to the engine.
// Per matrix: 12 minors, then the determinant, then per element 3 cofactor
// terms plus a 98-step bit-serial divide; a singular matrix emits the identity.
// full is high while a started matrix waits for the engine; a full result
// queue stalls the engine. Reset clears the matrix and sets threshold 43.
module matrix_inverse_4x4 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mi4_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output mi4_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import mi4_pkg::*;

    logic      [31:0] thr_reg;
    logic             job_valid, job_take;
    matrix_t          job_mat;
    logic             res_push, res_full;
    out_item_t        res_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 32'd43;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    mi4_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_valid),
        .job_mat   (job_mat),
        .job_take  (job_take)
    );

    mi4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_mat   (job_mat),
        .job_take  (job_take),
        .threshold (thr_reg),
        .res_push  (res_push),
        .res_item  (res_item),
        .res_full  (res_full)
    );

    mi4_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (res_push),
        .wr_item  (res_item),
        .wr_full  (res_full),
        .rd       (pop),
        .rd_item  (result),
        .rd_empty (empty)
    );

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last) |->
        (result.out_outer_index == 2'd3 && result.out_inner_index == 2'd3))
        else $error("last item not at position 3,3");

    a_ident_off: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.singular && result.out_outer_index != result.out_inner_index)
        |-> (result.result_value == '0 && !result.saturated))
        else $error("identity off-diagonal not zero");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.saturated && !result.singular) |->
        (result.result_value == 32'(MAXPOS) || result.result_value == 32'(~MAXPOS)))
        else $error("saturated item not at a range limit");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> !full)
        else $error("handoff slot not freed");

endmodule

### dv/matrix_inverse_4x4_tb.sv
module matrix_inverse_4x4_tb;
    import mi4_pkg::*;

    localparam int PERIOD = 12;

    // cofactor terms per result element: matrix element index and minor index
    localparam logic [3:0] TERM_ELEM [48] = '{
        4'd5, 4'd6, 4'd7,   4'd1, 4'd2, 4'd3,   4'd13, 4'd14, 4'd15,   4'd9, 4'd10, 4'd11,
        4'd4, 4'd6, 4'd7,   4'd0, 4'd2, 4'd3,   4'd12, 4'd14, 4'd15,   4'd8, 4'd10, 4'd11,
        4'd4, 4'd5, 4'd7,   4'd0, 4'd1, 4'd3,   4'd12, 4'd13, 4'd15,   4'd8, 4'd9, 4'd11,
        4'd4, 4'd5, 4'd6,   4'd0, 4'd1, 4'd2,   4'd12, 4'd13, 4'd14,   4'd8, 4'd9, 4'd10
    };
    localparam logic [3:0] TERM_MINOR [48] = '{
        4'd11, 4'd10, 4'd9,   4'd11, 4'd10, 4'd9,   4'd5, 4'd4, 4'd3,   4'd5, 4'd4, 4'd3,
        4'd11, 4'd8, 4'd7,    4'd11, 4'd8, 4'd7,    4'd5, 4'd2, 4'd1,   4'd5, 4'd2, 4'd1,
        4'd10, 4'd8, 4'd6,    4'd10, 4'd8, 4'd6,    4'd4, 4'd2, 4'd0,   4'd4, 4'd2, 4'd0,
        4'd9, 4'd7, 4'd6,     4'd9, 4'd7, 4'd6,     4'd3, 4'd1, 4'd0,   4'd3, 4'd1, 4'd0
    };
    localparam logic [1:0] PAIR_LO [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_HI [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    localparam logic [5:0] DET_MINUS = 6'b010010;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   item;
    logic       empty;
    logic       pop;
    out_item_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [31:0] cfg_data;

    matrix_inverse_4x4 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    logic signed [31:0] shadow_matrix [16];
    logic [31:0]        shadow_threshold;
    out_item_t          inverse_queue [$];
    int                 error_count;
    int                 send_idle;
    int                 recv_idle;

    always
    begin
        clk = 1'b0;
        #(PERIOD / 2);
        clk = 1'b1;
        #(PERIOD / 2);
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle);
    end

    // element loads, then the full cofactor inverse (or the identity if singular) when start_req is set
    task automatic predict_inverse(input in_item_t it);
        logic signed [63:0]  minor_val [12];
        logic signed [191:0] acc;
        logic signed [191:0] x;
        logic signed [191:0] y;
        logic [191:0]        mag;
        logic [191:0]        quot;
        logic [191:0]        rem;
        logic [191:0]        dmag_w;
        logic [63:0]         det_val;
        logic [63:0]         dmag;
        logic [63:0]         maxpos;
        logic [63:0]         one;
        logic                neg;
        logic                dneg;
        logic                odd;
        logic                clip;
        out_item_t           r;
        int                  e;
        shadow_matrix[{it.outer_index, it.inner_index}] = it.element_value;
        if (!it.start_req)
            return;
        for (int k = 0; k < 6; k++)
        begin
            minor_val[k] = longint'(shadow_matrix[PAIR_LO[k]]) *
                           longint'(shadow_matrix[4 + PAIR_HI[k]]) -
                           longint'(shadow_matrix[4 + PAIR_LO[k]]) *
                           longint'(shadow_matrix[PAIR_HI[k]]);
            minor_val[6 + k] = longint'(shadow_matrix[8 + PAIR_LO[k]]) *
                               longint'(shadow_matrix[12 + PAIR_HI[k]]) -
                               longint'(shadow_matrix[12 + PAIR_LO[k]]) *
                               longint'(shadow_matrix[8 + PAIR_HI[k]]);
        end
        acc = '0;
        for (int k = 0; k < 6; k++)
        begin
            x = 192'(minor_val[k]);
            y = 192'(minor_val[11 - k]);
            acc = DET_MINUS[k] ? acc - x * y : acc + x * y;
        end
        neg = acc[191];
        mag = neg ? -acc : acc;
        mag = (mag + (192'd1 << (2 * FRACTION_BITS - 1))) >> (2 * FRACTION_BITS);
        if (neg)
        begin
            if (mag > (192'd1 << 63))
                mag = 192'd1 << 63;
            det_val = -mag[63:0];
        end
        else
        begin
            if (mag > ((192'd1 << 63) - 1))
                mag = (192'd1 << 63) - 1;
            det_val = mag[63:0];
        end
        dneg = det_val[63];
        dmag = dneg ? -det_val : det_val;
        maxpos = (64'd1 << (ELEMENT_WIDTH - 1)) - 64'd1;
        for (int k = 0; k < 16; k++)
        begin
            r.out_outer_index = 2'(k >> 2);
            r.out_inner_index = 2'(k);
            r.last = (k == 15);
            if (dmag == 0 || dmag < {32'd0, shadow_threshold})
            begin
                one = 64'd1 << FRACTION_BITS;
                clip = one > maxpos;
                if (clip)
                    one = maxpos;
                r.singular = 1'b1;
                r.result_value = ((k >> 2) == (k & 3)) ? 32'(one) : 32'sd0;
                r.saturated = ((k >> 2) == (k & 3)) && clip;
            end
            else
            begin
                odd = (((k >> 2) + (k & 3)) & 1) != 0;
                acc = '0;
                for (int t = 0; t < 3; t++)
                begin
                    e = k * 3 + t;
                    x = 192'(shadow_matrix[TERM_ELEM[e]]);
                    y = 192'(minor_val[TERM_MINOR[e]]);
                    acc = (odd != (t == 1)) ? acc - x * y : acc + x * y;
                end
                neg = acc[191];
                mag = neg ? -acc : acc;
                dmag_w = {128'd0, dmag};
                quot = mag / dmag_w;
                rem = mag % dmag_w;
                if (rem >= dmag_w - rem)
                    quot = quot + 192'd1;
                r.singular = 1'b0;
                r.saturated = 1'b0;
                if (neg != dneg)
                begin
                    if (quot > {128'd0, maxpos + 64'd1})
                    begin
                        quot = {128'd0, maxpos + 64'd1};
                        r.saturated = 1'b1;
                    end
                    r.result_value = 32'(-quot);
                end
                else
                begin
                    if (quot > {128'd0, maxpos})
                    begin
                        quot = {128'd0, maxpos};
                        r.saturated = 1'b1;
                    end
                    r.result_value = 32'(quot);
                end
            end
            inverse_queue.push_back(r);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (inverse_queue.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                if (result.out_outer_index !== inverse_queue[0].out_outer_index ||
                    result.out_inner_index !== inverse_queue[0].out_inner_index ||
                    result.result_value !== inverse_queue[0].result_value ||
                    result.singular !== inverse_queue[0].singular ||
                    result.saturated !== inverse_queue[0].saturated ||
                    result.last !== inverse_queue[0].last)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected %h actual %h",
                             $time, inverse_queue[0], result);
                end
                void'(inverse_queue.pop_front());
            end
        end
    end

    task automatic send_element(input logic [1:0] outer, input logic [1:0] inner,
                                input logic signed [31:0] value, input logic start);
        in_item_t it;
        logic     taken;
        it.outer_index = outer;
        it.inner_index = inner;
        it.element_value = value;
        it.start_req = start;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        predict_inverse(it);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (inverse_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        logic taken;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        shadow_threshold = value;
    endtask

    task automatic test_zero_matrix();
        send_element(2'd0, 2'd0, 32'sd0, 1'b1);
    endtask

    task automatic test_identity();
        for (int i = 0; i < 4; i++)
            send_element(2'(i), 2'(i), 32'sh10000, i == 3);
        send_element(2'd2, 2'd2, -32'sh10000, 1'b1);
    endtask

    task automatic test_tiny_determinant();
        for (int i = 0; i < 4; i++)
            send_element(2'(i), 2'(i), 32'sd256, i == 3);
        write_threshold(32'd0);
        send_element(2'd1, 2'd1, 32'sd256, 1'b1);
        write_threshold(32'hFFFF_FFFF);
        send_element(2'd0, 2'd3, 32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_extremes();
        write_threshold(32'd43);
        for (int i = 0; i < 4; i++)
            send_element(2'(i), 2'(i), (i & 1) ? 32'sh7FFF_FFFF : -32'sh8000_0000, i == 3);
        send_element(2'd3, 2'd0, 32'sh7FFF_FFFF, 1'b1);
        send_element(2'd0, 2'd3, 32'sh1, 1'b0);
        send_element(2'd1, 2'd2, -32'sh8000_0000, 1'b1);
    endtask

    function automatic logic signed [31:0] pick_value(input int kind);
        case (kind)
            0: return 32'($urandom_range(0, 32'h80000)) - 32'sh40000;
            1: return $urandom;
            default: return 32'(int'($urandom_range(0, 15)) - 8) <<< 16;
        endcase
    endfunction

    task automatic test_random_matrices(input int sidle, input int ridle, input int count);
        logic signed [31:0] vals [16];
        int                 sent;
        int                 kind;
        send_idle = sidle;
        recv_idle = ridle;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 75)
            begin
                kind = $urandom_range(0, 3);
                for (int i = 0; i < 16; i++)
                    vals[i] = pick_value(kind == 3 ? 0 : kind);
                if (kind == 3)
                    for (int i = 0; i < 4; i++)
                        vals[12 + i] = vals[8 + i];
                for (int i = 0; i < 16; i++)
                    send_element(2'(i >> 2), 2'(i), vals[i], i == 15);
                sent += 16;
            end
            else
            begin
                for (int i = $urandom_range(1, 4); i > 0; i--)
                begin
                    send_element(2'($urandom), 2'($urandom), pick_value($urandom_range(0, 2)),
                                 $urandom_range(99) < 30);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        send_idle = 0;
        recv_idle = 0;
        shadow_threshold = 32'd43;
        for (int i = 0; i < 16; i++)
            shadow_matrix[i] = '0;
        rst_n <= 1'b0;
        push <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_matrix();
        test_identity();
        test_tiny_determinant();
        test_extremes();
        write_threshold($urandom_range(0, 1000));
        test_random_matrices(36, 87, 110);
        write_threshold($urandom);
        test_random_matrices(87, 36, 110);
        write_threshold(32'd43);
        test_random_matrices(0, 0, 110);
        wait_drained();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(PERIOD * 4000000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
